// ===== hw/rtl/ipe_pkg.sv =====
// ----------------------------------------------------------------------------
// ipe_pkg
// shared widths, picture character codes and the character edit function
// ----------------------------------------------------------------------------
package ipe_pkg;

    localparam int VAL_W     = 64;
    localparam int PIC_MAX   = 32;
    localparam int PIC_AW    = $clog2(PIC_MAX);
    localparam int PIC_CW    = PIC_AW + 1;
    localparam int DIGIT_MAX = 20;
    localparam int BCD_W     = 4 * DIGIT_MAX;
    localparam int NL_W      = $clog2(DIGIT_MAX + 1);
    localparam int FL_W      = PIC_CW;
    localparam int J_W       = 6;

    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_Z     = 8'h7a;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;

    function automatic logic is_slot(input logic [7:0] pc);
        return (pc == CH_NINE) || (pc == CH_Z) || (pc == CH_STAR);
    endfunction

    // non-digit edit of one picture character
    function automatic logic [7:0] edit_other(
        input logic [7:0]      pc,
        input logic [FL_W-1:0] fl,
        input logic [NL_W-1:0] nl,
        input logic            pos,
        input logic            neg
    );
        logic [7:0] oc;
        oc = CH_SPACE;
        if (pc == CH_DOT || pc == CH_COMMA || pc == CH_SLASH || pc == CH_ZERO
            || pc == CH_DOLL)
        begin
            oc = pc;
        end
        else if (pc == CH_B)
        begin
            oc = CH_SPACE;
        end
        else if (pc == CH_PLUS || pc == CH_S || pc == CH_MINUS)
        begin
            if (pos && pc == CH_MINUS)
                oc = CH_PLUS;
            else if (neg)
                oc = CH_MINUS;
            else
                oc = CH_SPACE;
        end
        else if (pc == CH_Z || pc == CH_STAR)
        begin
            oc = CH_ZERO;
        end
        else if (fl <= FL_W'({1'b0, nl}) + FL_W'(1))
        begin
            oc = pc;
        end
        return oc;
    endfunction

endpackage

// ===== hw/rtl/ipe_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// ipe_bcd_conv
// shift-and-add-3 binary to decimal converter, then strips leading zeros
// ----------------------------------------------------------------------------
module ipe_bcd_conv
    import ipe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [VAL_W-1:0]   mag,
    output logic               done,
    output logic [BCD_W-1:0]   digits,
    output logic [NL_W-1:0]    nl
);

    typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_NORM} conv_state_t;

    conv_state_t        state_reg;
    logic [VAL_W-1:0]   bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [5:0]         cnt_reg;
    logic [NL_W-1:0]    nl_reg;
    logic               done_reg;
    logic [BCD_W-1:0]   bcd_adj;

    // add 3 to every nibble of 5 or more before the shift
    always_comb
    begin
        for (int k = 0; k < DIGIT_MAX; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            else
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            nl_reg    <= NL_W'(DIGIT_MAX);
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        bin_reg   <= mag;
                        bcd_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    {bcd_reg, bin_reg} <= {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(VAL_W - 1))
                    begin
                        nl_reg    <= NL_W'(DIGIT_MAX);
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (bcd_reg[BCD_W-1 -: 4] == 4'd0 && nl_reg > NL_W'(1))
                    begin
                        bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
                        nl_reg  <= nl_reg - NL_W'(1);
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign digits = bcd_reg;
    assign nl     = nl_reg;

endmodule

// ===== hw/rtl/integer_picture_editor.sv =====
// ----------------------------------------------------------------------------
// integer_picture_editor
// edits a signed 64-bit number through a numeric picture, one char per strobe
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     start / busy     func, value, pic_char, last
//  output    strobe           out_char, out_last
//
//  a load or a non-last picture item is taken without going busy
//  a last item runs the converter shift loop and zero strip, then two
//  sweeps over the picture store: one counts the digit slots, one
//  emits the edited chars
//  rst_n clears the count, the number and all control state
//  results leave one per strobe; the receiver cannot stall them
module integer_picture_editor
    import ipe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              func,
    input  logic signed [63:0] value,
    input  logic [7:0]        pic_char,
    input  logic              last,
    output logic              strobe,
    output logic [7:0]        out_char,
    output logic              out_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_CONV, S_CNT_RD, S_CNT_CHK, S_SETJ, S_EM_RD, S_EM_OUT
    } state_t;

    state_t             state_reg;
    logic [7:0]         store_mem [PIC_MAX];
    logic [7:0]         rdata_reg;
    logic [PIC_CW-1:0]  count_reg;
    logic [VAL_W-1:0]   number_reg;
    logic [PIC_CW-1:0]  idx_reg;
    logic [FL_W-1:0]    fl_reg;
    logic [J_W-1:0]     j_reg;
    logic               strobe_reg;
    logic [7:0]         out_char_reg;
    logic               out_last_reg;
    logic               conv_go;
    logic               conv_done;
    logic [BCD_W-1:0]   digits;
    logic [NL_W-1:0]    nl;
    logic [VAL_W-1:0]   mag;
    logic               neg;
    logic               pos;
    logic               accept;
    logic [3:0]         dig;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign neg     = number_reg[VAL_W-1];
    assign pos     = !neg && (number_reg != '0);
    assign mag     = neg ? (VAL_W'(0) - number_reg) : number_reg;
    assign conv_go = accept && func && last;

    ipe_bcd_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (conv_go),
        .mag    (mag),
        .done   (conv_done),
        .digits (digits),
        .nl     (nl)
    );

    // digit j counted from the most significant end
    always_comb
    begin
        dig = 4'd0;
        for (int k = 0; k < DIGIT_MAX; k++)
        begin
            if (j_reg[4:0] == 5'(k))
                dig = digits[BCD_W-1-4*k -: 4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && func && count_reg < PIC_CW'(PIC_MAX))
            store_mem[count_reg[PIC_AW-1:0]] <= pic_char;
        rdata_reg <= store_mem[idx_reg[PIC_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            number_reg   <= '0;
            idx_reg      <= '0;
            fl_reg       <= '0;
            j_reg        <= '0;
            strobe_reg   <= 1'b0;
            out_char_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            strobe_reg   <= 1'b0;
            out_last_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!func)
                        begin
                            number_reg <= value;
                            count_reg  <= '0;
                        end
                        else
                        begin
                            if (count_reg < PIC_CW'(PIC_MAX))
                                count_reg <= count_reg + PIC_CW'(1);
                            if (last)
                                state_reg <= S_CONV;
                        end
                    end
                end
                S_CONV:
                begin
                    if (conv_done)
                    begin
                        idx_reg   <= '0;
                        fl_reg    <= '0;
                        state_reg <= S_CNT_RD;
                    end
                end
                S_CNT_RD: state_reg <= S_CNT_CHK;
                S_CNT_CHK:
                begin
                    if (is_slot(rdata_reg))
                        fl_reg <= fl_reg + FL_W'(1);
                    if (idx_reg == count_reg - PIC_CW'(1))
                        state_reg <= S_SETJ;
                    else
                    begin
                        idx_reg   <= idx_reg + PIC_CW'(1);
                        state_reg <= S_CNT_RD;
                    end
                end
                S_SETJ:
                begin
                    if (fl_reg < FL_W'(nl))
                        j_reg <= J_W'(FL_W'(nl) - fl_reg);
                    else
                        j_reg <= '0;
                    idx_reg   <= '0;
                    state_reg <= S_EM_RD;
                end
                S_EM_RD: state_reg <= S_EM_OUT;
                S_EM_OUT:
                begin
                    strobe_reg <= 1'b1;
                    if (rdata_reg == CH_NINE)
                    begin
                        if (fl_reg <= FL_W'(nl) && j_reg < J_W'(DIGIT_MAX))
                        begin
                            out_char_reg <= CH_ZERO + {4'd0, dig};
                            j_reg        <= j_reg + J_W'(1);
                        end
                        else
                            out_char_reg <= CH_SPACE;
                        fl_reg <= fl_reg - FL_W'(1);
                    end
                    else
                        out_char_reg <= edit_other(rdata_reg, fl_reg, nl, pos, neg);
                    if (idx_reg == count_reg - PIC_CW'(1))
                    begin
                        out_last_reg <= 1'b1;
                        count_reg    <= '0;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + PIC_CW'(1);
                        state_reg <= S_EM_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign strobe   = strobe_reg;
    assign out_char = out_char_reg;
    assign out_last = out_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PIC_CW'(PIC_MAX))
        else $error("picture count above store size");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && out_last_reg) |-> (state_reg == S_IDLE && count_reg == '0))
        else $error("edit walk did not end on final char");

    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        out_last_reg |-> strobe_reg)
        else $error("final flag without strobe");

    a_no_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !$past(state_reg == S_EM_OUT)) |-> !strobe_reg)
        else $error("strobe outside edit walk");

endmodule
